/* design/pokt_pkg.sv */
// package for the priority ordered key table
// field widths, operation and status codes, cell types; no dependencies
package pokt_pkg;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 20;
  localparam int PRIO_W = 8;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_MISS = 2'd2;

  // contents of one cell
  typedef struct packed {
    logic              vld;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } cell_data_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } cell_ctrl_t;

endpackage

/* design/pokt_in_if.sv */
// input channel of the priority ordered key table
// depends on pokt_pkg
interface pokt_in_if import pokt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [KEY_W-1:0]  key;
  logic [PRIO_W-1:0] prio;

  modport source (output valid, output opcode, output key, output prio, input ready);
  modport sink (input valid, input opcode, input key, input prio, output ready);
endinterface

/* design/pokt_out_if.sv */
// result channel of the priority ordered key table
// depends on pokt_pkg
interface pokt_out_if import pokt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [PRIO_W-1:0] found_prio;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output found_prio, output occupancy,
                  input ready);
  modport sink (input valid, input status, input found_prio, input occupancy,
                output ready);
endinterface

/* design/priority_ordered_key_table_top.sv */
// top level of the priority ordered key table: chain of pokt_cell and result register
// depends on pokt_pkg, pokt_in_if, pokt_out_if, pokt_cell
//
//  channel | dir | fields                          | handshake
//  in_s    | in  | opcode, key, prio               | valid/ready
//  out_s   | out | status, found_prio, occupancy   | valid/ready
//
// one transaction per cycle while the result is not stalled: every cell compares
// against the item at once and the whole row shifts in the accepting cycle; the
// result is registered and appears in the cycle after acceptance
// the first-match chain through all CAPACITY cells sets the clock path
// reset (rst_n low, synchronous) empties the table and drops a pending result
// a stalled result holds in the output register; a new item is taken in the
// same cycle that register is emptied
module priority_ordered_key_table_top import pokt_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pokt_in_if.sink     in_s,
  pokt_out_if.source  out_s
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_vld_r;
  logic [ST_W-1:0]   status_r;
  logic [PRIO_W-1:0] fprio_r;
  logic [OCC_W-1:0]  occ_r;

  logic              accept;
  logic              full;
  logic              any_hit;
  cell_ctrl_t        ctl;
  logic [ST_W-1:0]   status_nxt;
  logic [PRIO_W-1:0] fprio_nxt;

  // chain wiring, one slot per cell plus the ends
  cell_data_t        cdata  [CAPACITY+1];
  logic              clt    [CAPACITY+1];
  logic              seen   [CAPACITY+1];
  logic [PRIO_W-1:0] hprio  [CAPACITY];
  logic [CAPACITY-1:0] cvld;
  logic [PRIO_W-1:0] hprio_or;

  // output register frees the input side as soon as it is taken
  assign in_s.ready = !out_vld_r || out_s.ready;
  assign accept     = in_s.valid && in_s.ready;
  assign full       = (count_r == CNT_W'(CAPACITY));

  assign ctl.ins  = accept && (in_s.opcode == OP_INSERT) && !full;
  assign ctl.rem  = accept && (in_s.opcode == OP_REMOVE);
  assign ctl.key  = in_s.key;
  assign ctl.prio = in_s.prio;

  // left end: nothing in front takes the new entry
  assign clt[0]   = 1'b0;
  assign seen[0]  = 1'b0;
  // right end: shifting left pulls in an empty slot
  assign cdata[CAPACITY] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      cell_data_t left_d;
      if (gi == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_rest
        assign left_d = cdata[gi-1];
      end

      pokt_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .left_data  (left_d),
        .left_lt    (clt[gi]),
        .right_data (cdata[gi+1]),
        .seen_in    (seen[gi]),
        .data       (cdata[gi]),
        .lt         (clt[gi+1]),
        .seen_out   (seen[gi+1]),
        .hit_prio   (hprio[gi])
      );

      assign cvld[gi] = cdata[gi].vld;
    end
  endgenerate

  assign any_hit = seen[CAPACITY];

  // only the first matching cell drives a nonzero priority
  always_comb begin
    hprio_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hprio_or = hprio_or | hprio[i];
    end
  end

  always_comb begin
    status_nxt = ST_OK;
    fprio_nxt  = '0;
    count_nxt  = count_r;
    unique case (in_s.opcode)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_FIND: begin
        if (any_hit) begin
          fprio_nxt = hprio_or;
        end else begin
          status_nxt = ST_MISS;
        end
      end
      OP_REMOVE: begin
        if (any_hit) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_MISS;
        end
      end
      default: begin
        // unused opcode: no change, plain ok
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r   <= count_nxt;
        out_vld_r <= 1'b1;
      end else if (out_s.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      fprio_r  <= fprio_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_s.valid      = out_vld_r;
  assign out_s.status     = status_r;
  assign out_s.found_prio = fprio_r;
  assign out_s.occupancy  = occ_r;

`ifndef ASSERT_OFF
  // occupied cells are exactly as many as the count says
  a_count_matches : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cvld) == int'(count_r))
    else $error("cell valid bits disagree with entry count");

  // occupied cells form a contiguous run from the front
  a_contiguous : assert property (@(posedge clk) disable iff (!rst_n)
    ((cvld & (cvld + CAPACITY'(1))) == '0))
    else $error("gap in occupied cells");

  // a dropped insert leaves the count unchanged
  a_full_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_s.opcode == OP_INSERT) && full) |=> (count_r == $past(count_r)))
    else $error("insert into full table changed count");

  // a transaction that matches no entry reports priority zero
  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !any_hit) |=> (fprio_r == '0))
    else $error("nonzero priority on miss");
`endif

endmodule

/* design/pokt_cell.sv */
// one cell of the sorted table: holds one entry, shifts with its neighbors
// depends on pokt_pkg
module pokt_cell import pokt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctl,
  input  cell_data_t        left_data,
  input  logic              left_lt,
  input  cell_data_t        right_data,
  input  logic              seen_in,
  output cell_data_t        data,
  output logic              lt,
  output logic              seen_out,
  output logic [PRIO_W-1:0] hit_prio
);

  cell_data_t data_r;
  cell_data_t data_nxt;
  logic       match;

  assign data     = data_r;
  // new priority goes in front of this cell
  assign lt       = !data_r.vld || (data_r.prio < ctl.prio);
  assign match    = data_r.vld && (data_r.key == ctl.key);
  assign seen_out = seen_in || match;
  assign hit_prio = (match && !seen_in) ? data_r.prio : '0;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins && lt) begin
      if (left_lt) begin
        data_nxt = left_data;
      end else begin
        data_nxt.vld  = 1'b1;
        data_nxt.key  = ctl.key;
        data_nxt.prio = ctl.prio;
      end
    end else if (ctl.rem && seen_out) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r.key  <= data_nxt.key;
    data_r.prio <= data_nxt.prio;
    if (!rst_n) begin
      data_r.vld <= 1'b0;
    end else begin
      data_r.vld <= data_nxt.vld;
    end
  end

endmodule
